/* rtl/nptc_pkg.sv */
// shared types, constants and helpers for the near plane triangle clipper
// used by nptc_div and near_plane_triangle_clipper
`default_nettype none

package nptc_pkg;

    localparam int EXTRA_VARYINGS_DEF = 4;
    localparam int WORD_W             = 32;
    localparam int VP_REGS            = 8;
    localparam int VP_IDX_W           = 3;
    localparam int VP_W               = 64;
    localparam int IN_DATA_W          = 256;
    localparam int IN_USER_W          = 2;
    localparam int OUT_DATA_W         = 224;
    localparam int DIV_W              = 34;
    localparam int ACC_W              = 51;
    localparam int PROD_W             = 65;

    localparam logic [1:0] CORNER_LAST = 2'd2;
    localparam logic [1:0] CORNER_NONE = 2'd3;
    localparam logic [2:0] VID_X1      = 3'd3;
    localparam logic [2:0] VID_X2      = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_WR, S_PLAN,
        S_IA0, S_IA1, S_IA2, S_IA3, S_IA4, S_IA5, S_IWT,
        S_IK0, S_IK1, S_IK2, S_IK3, S_IK4,
        S_ERD, S_EMUL, S_EACC, S_EDA, S_EDS, S_EDW, S_EOUT
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] num;
        logic signed [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] quo;
    } t_div_rsp;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > $signed({{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}})) begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (x < $signed({{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}})) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [1:0] nxt1(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : 2'(i + 2'd1);
    endfunction

    function automatic logic [1:0] nxt2(input logic [1:0] i);
        return nxt1(nxt1(i));
    endfunction

endpackage

`default_nettype wire

/* rtl/nptc_div.sv */
// iterative signed divider, q = n * 2^16 / d toward zero, saturated to 32 bits
// one quotient bit per cycle; uses nptc_pkg
`default_nettype none

module nptc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire nptc_pkg::t_div_req i_req,
    output nptc_pkg::t_div_rsp      o_rsp
);
    import nptc_pkg::*;

    localparam int STEPS = DIV_W + 16;
    localparam logic [5:0] LAST_STEP = 6'(STEPS - 1);

    logic                     r_busy;
    logic [5:0]               r_cnt;
    logic [STEPS-1:0]         r_dvd;
    logic [STEPS-1:0]         r_quo;
    logic [DIV_W:0]           r_rem;
    logic [DIV_W-1:0]         r_den;
    logic                     r_neg;
    logic                     r_done;
    logic signed [WORD_W-1:0] r_res;

    logic [DIV_W:0]     rem_sh;
    logic               qbit;
    logic [DIV_W:0]     rem_nx;
    logic [STEPS-1:0]   quo_nx;
    logic [DIV_W-1:0]   num_mag;
    logic [DIV_W-1:0]   den_mag;
    logic [WORD_W-1:0]  sat_res;

    always_comb begin
        rem_sh = {r_rem[DIV_W-1:0], r_dvd[STEPS-1]};
        qbit   = (rem_sh >= {1'b0, r_den});
        rem_nx = qbit ? (rem_sh - {1'b0, r_den}) : rem_sh;
        quo_nx = {r_quo[STEPS-2:0], qbit};
        num_mag = i_req.num[DIV_W-1] ? DIV_W'(-i_req.num) : i_req.num;
        den_mag = i_req.den[DIV_W-1] ? DIV_W'(-i_req.den) : i_req.den;
        if (!r_neg) begin
            sat_res = (quo_nx > {{(STEPS-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}}) ?
                      {1'b0, {(WORD_W-1){1'b1}}} : quo_nx[WORD_W-1:0];
        end else begin
            sat_res = (quo_nx > {{(STEPS-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}}) ?
                      {1'b1, {(WORD_W-1){1'b0}}} : WORD_W'(-quo_nx[WORD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den == '0) begin
                    r_done <= 1'b1;
                    if (i_req.num == '0) begin
                        r_res <= '0;
                    end else if (i_req.num[DIV_W-1]) begin
                        r_res <= {1'b1, {(WORD_W-1){1'b0}}};
                    end else begin
                        r_res <= {1'b0, {(WORD_W-1){1'b1}}};
                    end
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_dvd  <= {num_mag, 16'd0};
                    r_quo  <= '0;
                    r_rem  <= '0;
                    r_den  <= den_mag;
                    r_neg  <= i_req.num[DIV_W-1] ^ i_req.den[DIV_W-1];
                end
            end else if (r_busy) begin
                r_rem <= rem_nx;
                r_quo <= quo_nx;
                r_dvd <= {r_dvd[STEPS-2:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= sat_res;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_res;

endmodule

`default_nettype wire

/* rtl/near_plane_triangle_clipper.sv */
// near plane triangle clipper top level: vertex store, sequencer, shared multiplier
// depends on nptc_pkg and nptc_div
//
// usage: vertices come in on the s_axis stream, one per transaction, with the
// corner number in tuser. corners 0 and 1 are stored; corner 2 is stored and
// starts the triangle; corner 3 is dropped. results leave on m_axis, one
// emitted vertex per transaction, tuser marks the third vertex of a triangle
// and tlast the last vertex of the run for the input triangle.
// a stored vertex is written as 4 + EXTRA_VARYINGS words. after corner 2 the triangle
// is planned; it yields 0 or 2 near-plane points and 0, 3 or 6 emitted vertices, and
// one 50-step divider is shared by all their divides. a zero divisor skips the steps.
// s_axis_tready is low while a vertex or a triangle is in work. one output register
// holds a finished vertex; when the receiver stalls the sequencer waits on it, and
// the block takes new input while the last vertex of a run waits to be taken.
// reset clears the viewport registers to zero and empties the output register.
// config writes go in through i_cfg_we / i_cfg_idx / i_cfg_data; the user is to make
// them while idle, as the block itself does not enforce it.
`default_nettype none

module near_plane_triangle_clipper #(
    parameter int EXTRA_VARYINGS = nptc_pkg::EXTRA_VARYINGS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [nptc_pkg::VP_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [nptc_pkg::VP_W-1:0]         i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x, pos_y, pos_z, pos_w, attr_a, attr_b, attr_c, attr_d
    input  wire logic [nptc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // corner
    input  wire logic [nptc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // screen_x, screen_y, screen_z, out_a, out_b, out_c, out_d
    output logic [nptc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // ends_triangle
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import nptc_pkg::*;

    localparam logic [2:0] K_LAST  = 3'(4 + EXTRA_VARYINGS - 1);
    localparam logic [3:0] VAR_END = 4'(3 + EXTRA_VARYINGS);

    // vertex store: corners 0..2 and the two near-plane points
    logic [WORD_W-1:0] r_mem [0:39];
    logic [WORD_W-1:0] r_rd;
    logic              mem_we;
    logic [5:0]        mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [5:0]        mem_raddr;

    logic [VP_W-1:0] r_vp [VP_REGS];

    t_state r_state, n_state;
    logic [2:0]               r_cnt, n_cnt;
    logic [IN_DATA_W-1:0]     r_in, n_in;
    logic [1:0]               r_corner, n_corner;
    logic [2:0]               r_clip, n_clip;
    logic [2:0]               r_list [6];
    logic [2:0]               n_list [6];
    logic                     r_six, n_six;
    logic [2:0]               r_eidx, n_eidx;
    logic                     r_job, n_job;
    logic [2:0]               r_ia [2];
    logic [2:0]               n_ia [2];
    logic [2:0]               r_ib [2];
    logic [2:0]               n_ib [2];
    logic signed [32:0]       r_d1, n_d1, r_d2, n_d2, r_diff, n_diff;
    logic signed [WORD_W-1:0] r_t, n_t, r_a, n_a;
    logic signed [WORD_W-1:0] r_v [4];
    logic signed [WORD_W-1:0] n_v [4];
    logic signed [WORD_W-1:0] r_row [4];
    logic signed [WORD_W-1:0] n_row [4];
    logic signed [WORD_W-1:0] r_res [7];
    logic signed [WORD_W-1:0] n_res [7];
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [1:0]               r_r, n_r, r_c, n_c;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0]    r_odata, n_odata;
    logic                     r_ouser, n_ouser, r_olast, n_olast;

    logic signed [32:0]       mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic [VP_W-1:0]          m_sel;
    logic [WORD_W-1:0]        m_val;
    logic [2:0]               vid;
    logic [2:0]               ia_cur, ib_cur;
    logic signed [ACC_W-1:0]  term, acc_sum, int_sum;
    logic                     in_clip;
    logic signed [32:0]       in_zw;
    logic [1:0]               nclip;
    logic [1:0]               cr, cp, cq;
    logic                     last_v;

    t_div_req div_req;
    t_div_rsp div_rsp;

    nptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VP_REGS; i++) begin
                r_vp[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_vp[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_cnt    <= n_cnt;
        r_in     <= n_in;
        r_corner <= n_corner;
        r_clip   <= n_clip;
        r_list   <= n_list;
        r_six    <= n_six;
        r_eidx   <= n_eidx;
        r_job    <= n_job;
        r_ia     <= n_ia;
        r_ib     <= n_ib;
        r_d1     <= n_d1;
        r_d2     <= n_d2;
        r_diff   <= n_diff;
        r_t      <= n_t;
        r_a      <= n_a;
        r_v      <= n_v;
        r_row    <= n_row;
        r_res    <= n_res;
        r_acc    <= n_acc;
        r_r      <= n_r;
        r_c      <= n_c;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
        r_olast  <= n_olast;
    end

    always_comb begin
        vid    = r_list[r_eidx];
        ia_cur = r_ia[r_job];
        ib_cur = r_ib[r_job];
        m_sel  = r_vp[{r_r, r_c[1]}];
        m_val  = r_c[0] ? m_sel[63:32] : m_sel[31:0];
        mul_a  = (r_state == S_EMUL) ? {m_val[31], m_val} : r_diff;
        mul_b  = (r_state == S_EMUL) ? r_v[r_c] : r_t;
        term   = {{2{r_prod[PROD_W-1]}}, r_prod[PROD_W-1:16]};
        acc_sum = r_acc + term;
        int_sum = {{(ACC_W-WORD_W){r_a[WORD_W-1]}}, r_a} + term;
        in_zw  = {s_axis_tdata[127], s_axis_tdata[127:96]}
               + {s_axis_tdata[95], s_axis_tdata[95:64]};
        in_clip = s_axis_tdata[127] || (s_axis_tdata[127:96] == '0) || in_zw[32];
        nclip  = {1'b0, r_clip[0]} + {1'b0, r_clip[1]} + {1'b0, r_clip[2]};
        cr     = r_clip[0] ? 2'd0 : (r_clip[1] ? 2'd1 : 2'd2);
        cp     = nxt1(cr);
        cq     = nxt2(cr);
        last_v = r_six ? (r_eidx == 3'd5) : (r_eidx == 3'd2);
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_in     = r_in;
        n_corner = r_corner;
        n_clip   = r_clip;
        n_list   = r_list;
        n_six    = r_six;
        n_eidx   = r_eidx;
        n_job    = r_job;
        n_ia     = r_ia;
        n_ib     = r_ib;
        n_d1     = r_d1;
        n_d2     = r_d2;
        n_diff   = r_diff;
        n_t      = r_t;
        n_a      = r_a;
        n_v      = r_v;
        n_row    = r_row;
        n_res    = r_res;
        n_acc    = r_acc;
        n_r      = r_r;
        n_c      = r_c;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;
        n_ovalid = (r_ovalid && m_axis_tready) ? 1'b0 : r_ovalid;

        s_axis_tready = (r_state == S_IDLE);
        mem_we    = 1'b0;
        mem_waddr = {1'b0, r_corner, r_cnt};
        mem_wdata = r_in[{r_cnt, 5'd0} +: WORD_W];
        mem_raddr = {vid, r_cnt};
        div_req.start = 1'b0;
        div_req.num   = {{2{r_d1[32]}}, r_d1[31:0]};
        div_req.den   = {r_d1[32], r_d1} - {r_d2[32], r_d2};

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tuser != CORNER_NONE) begin
                    n_in     = s_axis_tdata;
                    n_corner = s_axis_tuser;
                    n_clip[s_axis_tuser] = in_clip;
                    n_cnt    = '0;
                    n_state  = S_WR;
                end
            end
            S_WR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == K_LAST) begin
                    n_state = (r_corner == CORNER_LAST) ? S_PLAN : S_IDLE;
                end
            end
            S_PLAN: begin
                n_job  = 1'b0;
                n_eidx = '0;
                n_cnt  = '0;
                n_six  = 1'b0;
                case (nclip)
                    2'd0: begin
                        n_list[0] = 3'd0;
                        n_list[1] = 3'd1;
                        n_list[2] = 3'd2;
                        n_state   = S_ERD;
                    end
                    2'd1: begin
                        n_ia[0] = {1'b0, cq};
                        n_ib[0] = {1'b0, cr};
                        n_ia[1] = {1'b0, cp};
                        n_ib[1] = {1'b0, cr};
                        n_list[0] = {1'b0, cp};
                        n_list[1] = {1'b0, cq};
                        n_list[2] = VID_X1;
                        n_list[3] = {1'b0, cp};
                        n_list[4] = VID_X1;
                        n_list[5] = VID_X2;
                        n_six   = 1'b1;
                        n_state = S_IA0;
                    end
                    2'd2: begin
                        n_ia[0] = {1'b0, cp};
                        n_ib[0] = {1'b0, nxt1(cp)};
                        n_ia[1] = {1'b0, cp};
                        n_ib[1] = {1'b0, nxt2(cp)};
                        n_list[0] = {1'b0, cp};
                        n_list[1] = VID_X1;
                        n_list[2] = VID_X2;
                        n_state = S_IA0;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                // with two clipped corners the kept one follows the single clipped
                // pattern inverted: recompute the kept corner
                if (nclip == 2'd2) begin
                    n_ia[0]   = !r_clip[0] ? 3'd0 : (!r_clip[1] ? 3'd1 : 3'd2);
                    n_ia[1]   = n_ia[0];
                    n_ib[0]   = {1'b0, nxt1(n_ia[0][1:0])};
                    n_ib[1]   = {1'b0, nxt2(n_ia[0][1:0])};
                    n_list[0] = n_ia[0];
                end
            end
            S_IA0: begin
                mem_raddr = {ia_cur, 3'd2};
                n_state = S_IA1;
            end
            S_IA1: begin
                mem_raddr = {ia_cur, 3'd3};
                n_d1 = {r_rd[31], r_rd};
                n_state = S_IA2;
            end
            S_IA2: begin
                mem_raddr = {ib_cur, 3'd2};
                n_d1 = r_d1 + {r_rd[31], r_rd};
                n_state = S_IA3;
            end
            S_IA3: begin
                mem_raddr = {ib_cur, 3'd3};
                n_d2 = {r_rd[31], r_rd};
                n_state = S_IA4;
            end
            S_IA4: begin
                n_d2 = r_d2 + {r_rd[31], r_rd};
                n_state = S_IA5;
            end
            S_IA5: begin
                div_req.start = 1'b1;
                n_state = S_IWT;
            end
            S_IWT: begin
                if (div_rsp.done) begin
                    n_t     = div_rsp.quo;
                    n_cnt   = '0;
                    n_state = S_IK0;
                end
            end
            S_IK0: begin
                mem_raddr = {ia_cur, r_cnt};
                n_state = S_IK1;
            end
            S_IK1: begin
                mem_raddr = {ib_cur, r_cnt};
                n_a = r_rd;
                n_state = S_IK2;
            end
            S_IK2: begin
                n_diff = {r_rd[31], r_rd} - {r_a[31], r_a};
                n_state = S_IK3;
            end
            S_IK3: begin
                n_state = S_IK4;
            end
            S_IK4: begin
                mem_we    = 1'b1;
                mem_waddr = {r_job ? VID_X2 : VID_X1, r_cnt};
                mem_wdata = sat32(int_sum);
                n_cnt     = r_cnt + 3'd1;
                if (r_cnt == K_LAST) begin
                    n_cnt = '0;
                    if (!r_job) begin
                        n_job   = 1'b1;
                        n_state = S_IA0;
                    end else begin
                        n_eidx  = '0;
                        n_state = S_ERD;
                    end
                end else begin
                    n_state = S_IK0;
                end
            end
            S_ERD: begin
                mem_raddr = {vid, r_cnt};
                if (r_cnt != 3'd0) begin
                    n_v[r_cnt[1:0] - 2'd1] = r_rd;
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_r     = '0;
                    n_c     = '0;
                    n_acc   = '0;
                    n_state = S_EMUL;
                end
            end
            S_EMUL: begin
                n_state = S_EACC;
            end
            S_EACC: begin
                n_state = S_EMUL;
                if (r_c == 2'd3) begin
                    n_row[r_r] = sat32(acc_sum);
                    n_acc = '0;
                    n_c   = '0;
                    n_r   = r_r + 2'd1;
                    if (r_r == 2'd3) begin
                        n_cnt   = '0;
                        n_state = S_EDA;
                    end
                end else begin
                    n_acc = acc_sum;
                    n_c   = r_c + 2'd1;
                end
            end
            S_EDA: begin
                mem_raddr = {vid, r_cnt + 3'd1};
                if ({1'b0, r_cnt} >= VAR_END) begin
                    n_res[r_cnt] = '0;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd6) begin
                        n_state = S_EOUT;
                    end
                end else begin
                    n_state = S_EDS;
                end
            end
            S_EDS: begin
                div_req.start = 1'b1;
                div_req.num   = (r_cnt < 3'd3) ?
                                {{2{r_row[r_cnt[1:0]][31]}}, r_row[r_cnt[1:0]]} :
                                {{2{r_rd[31]}}, r_rd};
                div_req.den   = {{2{r_row[3][31]}}, r_row[3]};
                n_state = S_EDW;
            end
            S_EDW: begin
                if (div_rsp.done) begin
                    n_res[r_cnt] = div_rsp.quo;
                    n_cnt = r_cnt + 3'd1;
                    n_state = (r_cnt == 3'd6) ? S_EOUT : S_EDA;
                end
            end
            S_EOUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_res[6], r_res[5], r_res[4], r_res[3],
                                r_res[2], r_res[1], r_res[0]};
                    n_ouser  = (r_eidx == 3'd2) || (r_eidx == 3'd5);
                    n_olast  = last_v;
                    n_cnt    = '0;
                    if (last_v) begin
                        n_state = S_IDLE;
                    end else begin
                        n_eidx  = r_eidx + 3'd1;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire
